FILE: hw/rtl/tps_pkg.sv
`timescale 1ns / 1ps

package tps_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_STEPS = 16;
    localparam int POLY_MAX  = 4;

    // one vertex: [0] x, [1] y, [2] z
    typedef logic [2:0][31:0] vec_t;
    // three vertices: [vertex][coord]
    typedef logic [2:0][2:0][31:0] tri_v_t;

    typedef enum logic [1:0] {
        CFG_NORMAL_X = 2'd0,
        CFG_NORMAL_Y = 2'd1,
        CFG_NORMAL_Z = 2'd2,
        CFG_OFFSET   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
    } tri_in_t;

    typedef struct packed {
        logic               side;
        logic signed [31:0] out_a_x;
        logic signed [31:0] out_a_y;
        logic signed [31:0] out_a_z;
        logic signed [31:0] out_b_x;
        logic signed [31:0] out_b_y;
        logic signed [31:0] out_b_z;
        logic signed [31:0] out_c_x;
        logic signed [31:0] out_c_y;
        logic signed [31:0] out_c_z;
        logic               last;
    } tri_out_t;

    // exact plane distance as sign and magnitude
    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } dist_t;

    // per-vertex / per-edge classification
    typedef struct packed {
        logic [2:0] front_in;
        logic [2:0] back_in;
        logic [2:0] crosses;
    } edge_flags_t;

    function automatic tri_v_t tri_verts(tri_in_t t);
        tri_verts = {t.c_z, t.c_y, t.c_x, t.b_z, t.b_y, t.b_x, t.a_z, t.a_y, t.a_x};
    endfunction

endpackage

FILE: hw/rtl/tps_dist.sv
`timescale 1ns / 1ps

// n.p + d*2^16 per vertex, three stages: products, pair sums, final sum
module tps_dist (
    input  logic                  aclk,
    input  logic                  en,
    input  tps_pkg::vec_t         normal,
    input  logic [31:0]           offset,
    input  tps_pkg::tri_v_t       verts,
    output tps_pkg::dist_t [2:0]  dist_out
);
    import tps_pkg::*;

    logic signed [63:0] prod_reg [3][3];
    logic signed [63:0] off_reg;
    logic signed [64:0] s01_reg [3];
    logic signed [64:0] s23_reg [3];
    dist_t [2:0]        dist_reg;
    dist_t [2:0]        dist_next;
    logic signed [65:0] sum [3];
    logic signed [65:0] nsum [3];

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            sum[v]  = 66'(s01_reg[v]) + 66'(s23_reg[v]);
            nsum[v] = -66'(s01_reg[v]) - 66'(s23_reg[v]);
            dist_next[v].neg = sum[v][65];
            dist_next[v].mag = sum[v][65] ? nsum[v][63:0] : sum[v][63:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int v = 0; v < 3; v++) begin
                for (int k = 0; k < 3; k++) begin
                    prod_reg[v][k] <= $signed(normal[k]) * $signed(verts[v][k]);
                end
                s01_reg[v] <= 65'(prod_reg[v][0]) + 65'(prod_reg[v][1]);
                s23_reg[v] <= 65'(prod_reg[v][2]) + 65'(off_reg);
            end
            off_reg  <= {{16{offset[31]}}, offset, 16'h0000};
            dist_reg <= dist_next;
        end
    end

    assign dist_out = dist_reg;

endmodule

FILE: hw/rtl/tps_div.sv
`timescale 1ns / 1ps

// floor(a*2^16/(a+b)): prescale stage, then one restoring step per stage
module tps_div (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [15:0] q
);
    import tps_pkg::*;

    localparam int STEPS = DIV_STEPS;

    logic [63:0] s_reg [STEPS];
    logic [64:0] r_reg [STEPS];
    logic [15:0] q_reg [STEPS+1];
    logic [63:0] a_sc;
    logic [63:0] b_sc;

    always_comb begin
        if (a[63] || b[63]) begin
            a_sc = a >> 1;
            b_sc = b >> 1;
        end else begin
            a_sc = a;
            b_sc = b;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg[0] <= a_sc + b_sc;
            r_reg[0] <= {1'b0, a_sc};
            q_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [64:0] r2;
        logic        ge;

        assign r2 = {r_reg[k][63:0], 1'b0};
        assign ge = r2 >= {1'b0, s_reg[k]};

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k+1] <= {q_reg[k][14:0], ge};
            end
        end

        if (k < STEPS - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[k+1] <= ge ? (r2 - {1'b0, s_reg[k]}) : r2;
                    s_reg[k+1] <= s_reg[k];
                end
            end
        end
    end

    assign q = q_reg[STEPS];

endmodule

FILE: hw/rtl/tps_lerp.sv
`timescale 1ns / 1ps

// vi + floor((vj - vi) * q / 2^16), saturated; two stages
module tps_lerp (
    input  logic          aclk,
    input  logic          en,
    input  tps_pkg::vec_t vi,
    input  tps_pkg::vec_t vj,
    input  logic [15:0]   q,
    output tps_pkg::vec_t m
);
    import tps_pkg::*;

    logic signed [32:0] diff [3];
    logic signed [49:0] prod_reg [3];
    vec_t               vi_reg;
    vec_t               m_reg;
    vec_t               m_next;
    logic signed [49:0] shifted [3];
    logic signed [50:0] sum [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k]    = 33'($signed(vj[k])) - 33'($signed(vi[k]));
            shifted[k] = prod_reg[k] >>> FRAC_BITS;
            sum[k]     = 51'(shifted[k]) + 51'($signed(vi_reg[k]));
            if (sum[k] > 51'sd2147483647) begin
                m_next[k] = 32'h7fff_ffff;
            end else if (sum[k] < -51'sd2147483648) begin
                m_next[k] = 32'h8000_0000;
            end else begin
                m_next[k] = sum[k][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                prod_reg[k] <= 50'(diff[k]) * 50'($signed({1'b0, q}));
            end
            vi_reg <= vi;
            m_reg  <= m_next;
        end
    end

    assign m = m_reg;

endmodule

FILE: hw/rtl/tps_emit.sv
`timescale 1ns / 1ps

// polygon build stage, triangle fan, and result hold that drains one per transfer
module tps_emit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 vld_in,
    input  tps_pkg::tri_v_t      verts,
    input  tps_pkg::tri_v_t      cross_pts,
    input  tps_pkg::edge_flags_t flags,
    output logic                 en,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tps_pkg::tri_out_t    m_data
);
    import tps_pkg::*;

    typedef struct packed {
        logic   side;
        tri_v_t v;
    } tri_t;

    vec_t   slot [6];
    logic   fin [6];
    logic   bin [6];
    vec_t   fpoly [POLY_MAX];
    vec_t   bpoly [POLY_MAX];
    logic [2:0] nf;
    logic [2:0] nb;

    logic       poly_vld_reg;
    vec_t       front_reg [POLY_MAX];
    vec_t       back_reg [POLY_MAX];
    logic [2:0] nf_reg;
    logic [2:0] nb_reg;

    tri_t       tl [POLY_MAX];
    logic [2:0] tcnt;

    tri_t       tri_reg [POLY_MAX];
    logic [2:0] cnt_reg;
    logic [1:0] idx_reg;
    logic       hold_vld_reg;
    logic       last_now;
    tri_t       cur;

    // compact v0,m0,v1,m1,v2,m2 into each polygon
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            slot[2*i]   = verts[i];
            slot[2*i+1] = cross_pts[i];
            fin[2*i]    = flags.front_in[i];
            fin[2*i+1]  = flags.crosses[i];
            bin[2*i]    = flags.back_in[i];
            bin[2*i+1]  = flags.crosses[i];
        end
        nf = '0;
        nb = '0;
        for (int p = 0; p < POLY_MAX; p++) begin
            fpoly[p] = '0;
            bpoly[p] = '0;
        end
        for (int s = 0; s < 6; s++) begin
            if (fin[s]) begin
                if (nf < 3'(POLY_MAX)) fpoly[nf[1:0]] = slot[s];
                nf = nf + 3'd1;
            end
            if (bin[s]) begin
                if (nb < 3'(POLY_MAX)) bpoly[nb[1:0]] = slot[s];
                nb = nb + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_vld_reg <= 1'b0;
        end else if (en) begin
            poly_vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            front_reg <= fpoly;
            back_reg  <= bpoly;
            nf_reg    <= nf;
            nb_reg    <= nb;
        end
    end

    // front fan first, then back fan
    always_comb begin
        tcnt = '0;
        for (int p = 0; p < POLY_MAX; p++) tl[p] = '0;
        if (nf_reg == 3'd3 || nf_reg == 3'd4) begin
            tl[tcnt[1:0]] = '{1'b0, {front_reg[2], front_reg[1], front_reg[0]}};
            tcnt = tcnt + 3'd1;
        end
        if (nf_reg == 3'd4) begin
            tl[tcnt[1:0]] = '{1'b0, {front_reg[3], front_reg[2], front_reg[0]}};
            tcnt = tcnt + 3'd1;
        end
        if (nb_reg == 3'd3 || nb_reg == 3'd4) begin
            tl[tcnt[1:0]] = '{1'b1, {back_reg[2], back_reg[1], back_reg[0]}};
            tcnt = tcnt + 3'd1;
        end
        if (nb_reg == 3'd4) begin
            tl[tcnt[1:0]] = '{1'b1, {back_reg[3], back_reg[2], back_reg[0]}};
            tcnt = tcnt + 3'd1;
        end
    end

    assign last_now = ({1'b0, idx_reg} + 3'd1) == cnt_reg;
    assign en       = !hold_vld_reg || (m_ready && last_now);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg <= 1'b0;
            idx_reg      <= '0;
            cnt_reg      <= '0;
        end else if (en) begin
            hold_vld_reg <= poly_vld_reg && (tcnt != 3'd0);
            idx_reg      <= '0;
            cnt_reg      <= tcnt;
        end else if (m_ready) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tri_reg <= tl;
        end
    end

    assign cur     = tri_reg[idx_reg];
    assign m_valid = hold_vld_reg;

    always_comb begin
        m_data.side    = cur.side;
        m_data.out_a_x = cur.v[0][0];
        m_data.out_a_y = cur.v[0][1];
        m_data.out_a_z = cur.v[0][2];
        m_data.out_b_x = cur.v[1][0];
        m_data.out_b_y = cur.v[1][1];
        m_data.out_b_z = cur.v[1][2];
        m_data.out_c_x = cur.v[2][0];
        m_data.out_c_y = cur.v[2][1];
        m_data.out_c_z = cur.v[2][2];
        m_data.last    = last_now;
    end

endmodule

FILE: hw/rtl/triangle_plane_splitter_top.sv
`timescale 1ns / 1ps

// Triangle/plane splitter. Each input transfer carries one triangle; the block
// classifies its vertices against the plane n.p + d (exact 66-bit distances),
// cuts crossing edges with a 16-bit quotient, and returns up to three triangles:
// front (side 0) first, then back (side 1), with last set on the final one. An
// item that yields no triangle produces no output transfer. The pipeline is 24
// register stages deep (input, three distance stages, a 17-stage divider,
// two interpolation stages, a polygon stage) plus the result hold register.
// An item enters every cycle while the pipeline is not stalled; an item with n
// results occupies the single result port for n transfers, and the whole
// pipeline stalls while the hold register still drains or its last result is
// not taken. Plane registers are written through cfg_we/cfg_index/cfg_wdata and
// must only change while the block is empty.
module triangle_plane_splitter_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tps_pkg::tri_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tps_pkg::tri_out_t  m_data,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wdata
);
    import tps_pkg::*;

    // stage numbering: 0 = input register
    localparam int DIST_LAT = 3;
    localparam int DIV_OUT  = DIST_LAT + DIV_STEPS + 1;
    localparam int EMIT_IN  = DIV_OUT + 2;

    logic [31:0] nx_reg;
    logic [31:0] ny_reg;
    logic [31:0] nz_reg;
    logic [31:0] off_reg;

    logic        en;
    logic        vld_reg [EMIT_IN+1];
    tri_v_t      vtx_reg [EMIT_IN+1];
    edge_flags_t flag_reg [DIST_LAT+1:EMIT_IN];
    edge_flags_t flags_next;
    dist_t [2:0] dist_v;
    logic [15:0] q [3];
    tri_v_t      cross_pts;

    // plane registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nx_reg  <= 32'h0000_0000;
            ny_reg  <= 32'h0000_0000;
            nz_reg  <= 32'h0001_0000;
            off_reg <= 32'h0000_0000;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_NORMAL_X: nx_reg  <= cfg_wdata;
                CFG_NORMAL_Y: ny_reg  <= cfg_wdata;
                CFG_NORMAL_Z: nz_reg  <= cfg_wdata;
                CFG_OFFSET:   off_reg <= cfg_wdata;
            endcase
        end
    end

    // the whole pipe moves together; the emitter decides when
    assign s_ready = en;

    // valid line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= EMIT_IN; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k <= EMIT_IN; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    // vertex delay line, tapped at the distance unit, the interpolators and the emitter
    always_ff @(posedge aclk) begin
        if (en) begin
            vtx_reg[0] <= tri_verts(s_data);
            for (int k = 1; k <= EMIT_IN; k++) vtx_reg[k] <= vtx_reg[k-1];
        end
    end

    tps_dist u_dist (
        .aclk     (aclk),
        .en       (en),
        .normal   ({nz_reg, ny_reg, nx_reg}),
        .offset   (off_reg),
        .verts    (vtx_reg[0]),
        .dist_out (dist_v)
    );

    // front: D >= 0, back: D <= 0, cross: strictly opposite signs
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            flags_next.front_in[i] = !dist_v[i].neg;
            flags_next.back_in[i]  = dist_v[i].neg || (dist_v[i].mag == 64'd0);
            flags_next.crosses[i]  = (dist_v[i].mag != 64'd0)
                                  && (dist_v[(i+1)%3].mag != 64'd0)
                                  && (dist_v[i].neg != dist_v[(i+1)%3].neg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flag_reg[DIST_LAT+1] <= flags_next;
            for (int k = DIST_LAT + 2; k <= EMIT_IN; k++) flag_reg[k] <= flag_reg[k-1];
        end
    end

    // one divider and one interpolator per edge i -> i+1
    for (genvar i = 0; i < 3; i++) begin : g_edge
        localparam int J = (i + 1) % 3;

        tps_div u_div (
            .aclk (aclk),
            .en   (en),
            .a    (dist_v[i].mag),
            .b    (dist_v[J].mag),
            .q    (q[i])
        );

        tps_lerp u_lerp (
            .aclk (aclk),
            .en   (en),
            .vi   (vtx_reg[DIV_OUT][i]),
            .vj   (vtx_reg[DIV_OUT][J]),
            .q    (q[i]),
            .m    (cross_pts[i])
        );
    end

    tps_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .vld_in    (vld_reg[EMIT_IN]),
        .verts     (vtx_reg[EMIT_IN]),
        .cross_pts (cross_pts),
        .flags     (flag_reg[EMIT_IN]),
        .en        (en),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTHESIS
    // nothing pending at the output means the pipe must be moving
    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result pending");

    // results of one triangle stay valid without a gap until last
    a_burst_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last) |=> m_valid)
        else $error("result burst broken before last");

    // input is held off while a multi-result burst drains
    a_burst_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last) |-> !s_ready)
        else $error("input accepted mid burst");
`endif

endmodule
